>>> hdl/spd_pkg.sv
// Package for the sequential access prefetch detector.
// Holds payload and configuration types, register codes and default sizes.
`timescale 1ns / 1ps

package spd_pkg;

  localparam int MAX_WINDOW_DEF = 16;
  localparam int THR_W          = 5;
  localparam int BLK_W          = 32;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_TOTAL     = 1'b1;

  typedef struct packed {
    logic [BLK_W-1:0] block_number;
  } req_item_t;

  typedef struct packed {
    logic             prefetch_valid;
    logic [BLK_W-1:0] prefetch_block;
  } rsp_item_t;

  typedef struct packed {
    logic [THR_W-1:0] window_threshold;
    logic [BLK_W-1:0] total_blocks;
    logic             clear;
  } cfg_t;

endpackage

>>> hdl/spd_stream_if.sv
// Valid/ready stream interface for one beat of payload of type T.
// No dependencies.
`timescale 1ns / 1ps

interface spd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/spd_window_mem.sv
// Window store: one synchronous RAM, one write and one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module spd_window_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 36,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/spd_cfg.sv
// APB register port: window threshold and total block count.
// Depends on spd_pkg.
`timescale 1ns / 1ps

module spd_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spd_pkg::PADDR_W-1:0] paddr,
  input  logic [spd_pkg::PDATA_W-1:0] pwdata,
  output logic [spd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output spd_pkg::cfg_t               cfg
);

  logic                       wr;
  logic                       sel;
  logic [spd_pkg::THR_W-1:0]  threshold;
  logic [spd_pkg::BLK_W-1:0]  total;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign sel    = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
      total     <= '0;
    end else if (wr) begin
      if (sel == spd_pkg::REG_THRESHOLD) begin
        threshold <= pwdata[spd_pkg::THR_W-1:0];
      end else begin
        total <= pwdata[spd_pkg::BLK_W-1:0];
      end
    end
  end

  always_comb begin
    if (sel == spd_pkg::REG_THRESHOLD) begin
      prdata = spd_pkg::PDATA_W'(threshold);
    end else begin
      prdata = spd_pkg::PDATA_W'(total);
    end
  end

  assign cfg.window_threshold = threshold;
  assign cfg.total_blocks     = total;
  assign cfg.clear            = wr;

endmodule

>>> hdl/spd_ctrl.sv
// Sequencer: walks the window RAM to find, re-rank and insert a block, then
// checks the window span and forms the prefetch beat. Depends on spd_pkg.
`timescale 1ns / 1ps

module spd_ctrl #(
  parameter int MAX_WINDOW = spd_pkg::MAX_WINDOW_DEF,
  parameter int IW         = 4,
  parameter int CW         = 5,
  parameter int MW         = 36
) (
  input  logic              clk,
  input  logic              rst,
  input  spd_pkg::cfg_t     cfg,
  spd_stream_if.sink        req,
  spd_stream_if.source      rsp,
  output logic              mem_we,
  output logic [IW-1:0]     mem_waddr,
  output logic [MW-1:0]     mem_wdata,
  output logic [IW-1:0]     mem_raddr,
  input  logic [MW-1:0]     mem_rdata
);

  typedef enum logic [2:0] {IDLE, SEARCH, UPDATE, INSERT, CHECK, DONE} state_t;

  state_t                    state;
  logic [spd_pkg::BLK_W-1:0] blk;
  logic [CW-1:0]             fill;
  logic                      vknown;
  logic [CW-1:0]             issue_cnt;
  logic                      p_vld;
  logic [IW-1:0]             p_idx;
  logic                      hit;
  logic [IW-1:0]             hit_idx;
  logic [IW-1:0]             hit_rank;
  logic [IW-1:0]             evict_idx;
  logic [IW-1:0]             evict_rank;
  logic [spd_pkg::BLK_W-1:0] lo;
  logic [spd_pkg::BLK_W-1:0] hi;
  logic                      seq;
  logic                      out_valid;
  spd_pkg::rsp_item_t        out_item;

  logic [CW-1:0]             cap;
  logic                      issue;
  logic                      pass_done;
  logic                      full;
  logic [spd_pkg::BLK_W-1:0] q_blk;
  logic [IW-1:0]             q_rec;
  logic [spd_pkg::BLK_W-1:0] upd_blk;
  logic [IW-1:0]             upd_rec;
  logic [spd_pkg::BLK_W:0]   span;
  logic [spd_pkg::BLK_W:0]   next_blk;
  logic                      propose;
  logic                      load;

  always_comb begin
    if (32'(cfg.window_threshold) > 32'(MAX_WINDOW)) begin
      cap = CW'(MAX_WINDOW);
    end else begin
      cap = CW'(cfg.window_threshold);
    end
  end

  assign issue     = (state == SEARCH || state == UPDATE) && (issue_cnt < fill);
  assign pass_done = (issue_cnt == fill) && !p_vld;
  assign full      = (fill == cap);
  assign q_blk     = mem_rdata[MW-1:IW];
  assign q_rec     = mem_rdata[IW-1:0];
  assign mem_raddr = issue_cnt[IW-1:0];

  always_comb begin
    upd_blk = q_blk;
    upd_rec = IW'(q_rec + 1'b1);
    if (hit) begin
      if (p_idx == hit_idx) begin
        upd_rec = '0;
      end else if (q_rec >= hit_rank) begin
        upd_rec = q_rec;
      end
    end else if (full && p_idx == evict_idx) begin
      upd_blk = blk;
      upd_rec = '0;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = p_idx;
    mem_wdata = {upd_blk, upd_rec};
    if (state == UPDATE && p_vld) begin
      mem_we = 1'b1;
    end else if (state == INSERT) begin
      mem_we    = 1'b1;
      mem_waddr = fill[IW-1:0];
      mem_wdata = {blk, {IW{1'b0}}};
    end
  end

  assign span     = {1'b0, hi} - {1'b0, lo} + 1'b1;
  assign next_blk = {1'b0, hi} + 1'b1;
  assign propose  = seq && (next_blk < {1'b0, cfg.total_blocks});
  assign load     = (state == DONE) && (!out_valid || rsp.ready);

  assign req.ready = (state == IDLE) && !rst;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      fill      <= '0;
      vknown    <= 1'b0;
      p_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && !load) begin
        out_valid <= 1'b0;
      end
      p_vld <= issue;
      p_idx <= issue_cnt[IW-1:0];
      if (issue) begin
        issue_cnt <= CW'(issue_cnt + 1'b1);
      end
      case (state)
        IDLE: begin
          if (cfg.clear) begin
            fill   <= '0;
            vknown <= 1'b0;
          end
          if (req.valid) begin
            blk        <= req.data.block_number;
            lo         <= req.data.block_number;
            hi         <= req.data.block_number;
            issue_cnt  <= '0;
            hit        <= 1'b0;
            evict_idx  <= '0;
            evict_rank <= '0;
            seq        <= 1'b0;
            if (cap == '0) begin
              state <= DONE;
            end else begin
              state <= SEARCH;
            end
          end
        end
        SEARCH: begin
          if (p_vld) begin
            if (q_blk == blk && !hit) begin
              hit      <= 1'b1;
              hit_idx  <= p_idx;
              hit_rank <= q_rec;
            end
            if (q_rec > evict_rank) begin
              evict_idx  <= p_idx;
              evict_rank <= q_rec;
            end
          end
          if (pass_done) begin
            issue_cnt <= '0;
            state     <= UPDATE;
          end
        end
        UPDATE: begin
          if (p_vld) begin
            if (upd_blk < lo) begin
              lo <= upd_blk;
            end
            if (upd_blk > hi) begin
              hi <= upd_blk;
            end
          end
          if (pass_done) begin
            if (!hit && !full) begin
              state <= INSERT;
            end else begin
              if (!hit) begin
                vknown <= 1'b0;
              end
              state <= CHECK;
            end
          end
        end
        INSERT: begin
          fill  <= CW'(fill + 1'b1);
          state <= CHECK;
        end
        CHECK: begin
          if (full && !vknown) begin
            vknown <= 1'b1;
            seq    <= (span == (spd_pkg::BLK_W + 1)'(cap));
          end
          state <= DONE;
        end
        DONE: begin
          if (load) begin
            out_valid               <= 1'b1;
            out_item.prefetch_valid <= propose;
            out_item.prefetch_block <= propose ? next_blk[spd_pkg::BLK_W-1:0] : '0;
            state                   <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/sequential_access_prefetch_detector.sv
// From accept to result the beat passes two walks over the window RAM (search,
// then re-rank), an insert step when the block is inserted, the span check and
// the output load. Disabled (threshold zero): straight to the output load. One
// beat in flight; the result register lets the next beat enter while a result
// waits. Reset empties the window and clears both registers; the RAM is not
// cleared, only filled slots are read.
`timescale 1ns / 1ps

module sequential_access_prefetch_detector #(
  parameter int MAX_WINDOW = spd_pkg::MAX_WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  spd_stream_if.sink                  req,
  spd_stream_if.source                rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spd_pkg::PADDR_W-1:0] paddr,
  input  logic [spd_pkg::PDATA_W-1:0] pwdata,
  output logic [spd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int MW = spd_pkg::BLK_W + IW;

  spd_pkg::cfg_t cfg;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic [IW-1:0] mem_raddr;
  logic [MW-1:0] mem_rdata;

  spd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  spd_window_mem #(
    .DEPTH (MAX_WINDOW),
    .WIDTH (MW),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  spd_ctrl #(
    .MAX_WINDOW (MAX_WINDOW),
    .IW         (IW),
    .CW         (CW),
    .MW         (MW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule
